### sv/lcd4_pkg.sv
// types, codes and init tables for the 4-bit character lcd write sequencer
package lcd4_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_POWER_ON = 3'd1,
    OP_POWER_OFF = 3'd2,
    OP_BYTE     = 3'd3,
    OP_NIBBLE   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWER,
    PH_SETUP,
    PH_STROBE,
    PH_POST,
    PH_HOLD
  } phase_t;

  typedef enum logic [2:0] {
    REG_BIT_DELAY     = 3'd0,
    REG_COMMAND_DELAY = 3'd1,
    REG_POWER_DELAY   = 3'd2,
    REG_CLEAR_DELAY   = 3'd3,
    REG_WAKE_DELAY    = 3'd4,
    REG_FUNCTION_SET  = 3'd5
  } reg_idx_t;

  localparam int unsigned CFG_W = 16;
  localparam logic [3:0] INIT_ITEMS = 4'd10;
  localparam logic [3:0] FIRST_BYTE_ITEM = 4'd4;

  localparam logic [7:0] BIT_DELAY_RST     = 8'd4;
  localparam logic [9:0] COMMAND_DELAY_RST = 10'd25;
  localparam logic [15:0] POWER_DELAY_RST  = 16'd1000;
  localparam logic [9:0] CLEAR_DELAY_RST   = 10'd150;
  localparam logic [9:0] WAKE_DELAY_RST    = 10'd200;
  localparam logic [7:0] FUNCTION_SET_RST  = 8'h2c;

  // byte (or nibble) sent for init item k
  function automatic logic [7:0] init_byte(input logic [3:0] k, input logic [7:0] fs);
    logic [7:0] b;
    unique case (k)
      4'd0, 4'd1, 4'd2: b = 8'h03;
      4'd3: b = 8'h02;
      4'd4: b = fs;
      4'd5: b = 8'h08;
      4'd6: b = 8'h01;
      4'd7: b = 8'h06;
      4'd8: b = 8'h0c;
      4'd9: b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // wait after init item k
  function automatic logic [15:0] post_wait(input logic [3:0] k, input logic [9:0] wake,
                                            input logic [9:0] clr, input logic [9:0] cmd);
    logic [15:0] w;
    priority if (k < 4'd3) begin
      w = {6'd0, wake};
    end else if (k == 4'd6) begin
      w = {6'd0, clr};
    end else if (k == 4'd9) begin
      w = {5'd0, cmd, 1'b0} + {6'd0, cmd};
    end else begin
      w = {6'd0, cmd};
    end
    return w;
  endfunction

endpackage

### sv/char_lcd_4bit_write_sequencer.sv
// top level: 4-bit character lcd write sequencer with power and init sequencing
//
// Each accepted input beat is one microsecond tick and yields exactly one result beat
// with the pin levels after that tick. The sequencer state is updated by short logic at
// the input handshake and the result is held in an output register, so one beat is taken
// every cycle while the result side keeps up; a result waiting on out_ready holds off
// input only when the output register is full and not being taken. The user must write
// configuration registers via cfg_we/cfg_index/cfg_data only while idle (not enforced).
module char_lcd_4bit_write_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_operation,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_register_select,
  input  logic [11:0]                   in_hold_ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_lcd_enable,
  output logic                          out_lcd_rs,
  output logic                          out_lcd_rw,
  output logic [3:0]                    out_lcd_nibble,
  output logic                          out_power_enable,
  output logic                          out_pins_driven,
  output logic                          out_busy_res,
  output logic                          out_rejected,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [lcd4_pkg::CFG_W-1:0]    cfg_data
);

  // configuration
  logic [7:0]  bit_delay_r;
  logic [9:0]  command_delay_r;
  logic [15:0] power_delay_r;
  logic [9:0]  clear_delay_r;
  logic [9:0]  wake_delay_r;
  logic [7:0]  function_set_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_delay_r     <= lcd4_pkg::BIT_DELAY_RST;
      command_delay_r <= lcd4_pkg::COMMAND_DELAY_RST;
      power_delay_r   <= lcd4_pkg::POWER_DELAY_RST;
      clear_delay_r   <= lcd4_pkg::CLEAR_DELAY_RST;
      wake_delay_r    <= lcd4_pkg::WAKE_DELAY_RST;
      function_set_r  <= lcd4_pkg::FUNCTION_SET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcd4_pkg::REG_BIT_DELAY:     bit_delay_r     <= cfg_data[7:0];
        lcd4_pkg::REG_COMMAND_DELAY: command_delay_r <= cfg_data[9:0];
        lcd4_pkg::REG_POWER_DELAY:   power_delay_r   <= cfg_data[15:0];
        lcd4_pkg::REG_CLEAR_DELAY:   clear_delay_r   <= cfg_data[9:0];
        lcd4_pkg::REG_WAKE_DELAY:    wake_delay_r    <= cfg_data[9:0];
        lcd4_pkg::REG_FUNCTION_SET:  function_set_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  lcd4_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  init_step_r, init_step_nxt;
  logic [15:0] wait_count_r, wait_count_nxt;
  logic [7:0]  byte_latch_r, byte_latch_nxt;
  logic        select_latch_r, select_latch_nxt;
  logic        low_half_next_r, low_half_next_nxt;
  logic [11:0] hold_latch_r, hold_latch_nxt;
  logic        power_state_r, power_state_nxt;
  logic        driven_state_r, driven_state_nxt;
  logic [3:0]  bus_level_r, bus_level_nxt;
  logic        byte_mode_r, byte_mode_nxt;
  logic        rejected;

  logic        accept;
  logic        request;
  logic [3:0]  item_k;
  logic [7:0]  item_byte;
  logic [15:0] item_wait;
  logic [15:0] bit_wait;

  assign accept    = in_valid && in_ready;
  assign request   = (in_operation >= lcd4_pkg::OP_POWER_ON) &&
                     (in_operation <= lcd4_pkg::OP_NIBBLE);
  assign item_k    = (phase_r == lcd4_pkg::PH_POWER) ? 4'd0 : init_step_r;
  assign item_byte = lcd4_pkg::init_byte(item_k, function_set_r);
  assign item_wait = lcd4_pkg::post_wait(init_step_r - 4'd1, wake_delay_r,
                                         clear_delay_r, command_delay_r);
  assign bit_wait  = {8'd0, bit_delay_r};

  always_comb begin
    phase_nxt         = phase_r;
    init_step_nxt     = init_step_r;
    wait_count_nxt    = wait_count_r;
    byte_latch_nxt    = byte_latch_r;
    select_latch_nxt  = select_latch_r;
    low_half_next_nxt = low_half_next_r;
    hold_latch_nxt    = hold_latch_r;
    power_state_nxt   = power_state_r;
    driven_state_nxt  = driven_state_r;
    bus_level_nxt     = bus_level_r;
    byte_mode_nxt     = byte_mode_r;
    rejected          = 1'b0;
    if (phase_r != lcd4_pkg::PH_IDLE) begin
      rejected = request;
      if (wait_count_r > 16'd1) begin
        wait_count_nxt = wait_count_r - 16'd1;
      end else begin
        wait_count_nxt = 16'd0;
        unique case (phase_r)
          lcd4_pkg::PH_POWER, lcd4_pkg::PH_POST: begin
            if (phase_r == lcd4_pkg::PH_POST &&
                (init_step_r >= lcd4_pkg::INIT_ITEMS || init_step_r == 4'd0)) begin
              init_step_nxt = 4'd0;
              phase_nxt     = lcd4_pkg::PH_IDLE;
            end else begin
              // start the next init item
              init_step_nxt     = item_k + 4'd1;
              select_latch_nxt  = 1'b0;
              low_half_next_nxt = 1'b0;
              byte_latch_nxt    = item_byte;
              phase_nxt         = lcd4_pkg::PH_SETUP;
              wait_count_nxt    = bit_wait;
              if (item_k < lcd4_pkg::FIRST_BYTE_ITEM) begin
                byte_mode_nxt = 1'b0;
                bus_level_nxt = item_byte[3:0];
              end else begin
                byte_mode_nxt = 1'b1;
                bus_level_nxt = item_byte[7:4];
              end
            end
          end
          lcd4_pkg::PH_SETUP: begin
            phase_nxt      = lcd4_pkg::PH_STROBE;
            wait_count_nxt = bit_wait;
          end
          lcd4_pkg::PH_STROBE: begin
            if (byte_mode_r && !low_half_next_r) begin
              low_half_next_nxt = 1'b1;
              bus_level_nxt     = byte_latch_r[3:0];
              phase_nxt         = lcd4_pkg::PH_SETUP;
              wait_count_nxt    = bit_wait;
            end else if (init_step_r != 4'd0) begin
              phase_nxt      = lcd4_pkg::PH_POST;
              wait_count_nxt = item_wait;
            end else if (hold_latch_r == 12'd0) begin
              phase_nxt = lcd4_pkg::PH_IDLE;
            end else begin
              phase_nxt      = lcd4_pkg::PH_HOLD;
              wait_count_nxt = {4'd0, hold_latch_r};
            end
          end
          default: begin
            phase_nxt = lcd4_pkg::PH_IDLE;
          end
        endcase
      end
    end else begin
      unique case (in_operation)
        lcd4_pkg::OP_POWER_ON: begin
          power_state_nxt  = 1'b1;
          driven_state_nxt = 1'b1;
          bus_level_nxt    = 4'd0;
          select_latch_nxt = 1'b0;
          init_step_nxt    = 4'd0;
          phase_nxt        = lcd4_pkg::PH_POWER;
          wait_count_nxt   = power_delay_r;
        end
        lcd4_pkg::OP_POWER_OFF: begin
          power_state_nxt  = 1'b0;
          driven_state_nxt = 1'b0;
          bus_level_nxt    = 4'd0;
          select_latch_nxt = 1'b0;
        end
        lcd4_pkg::OP_BYTE, lcd4_pkg::OP_NIBBLE: begin
          init_step_nxt     = 4'd0;
          select_latch_nxt  = in_register_select;
          hold_latch_nxt    = in_hold_ticks;
          low_half_next_nxt = 1'b0;
          phase_nxt         = lcd4_pkg::PH_SETUP;
          wait_count_nxt    = bit_wait;
          if (in_operation == lcd4_pkg::OP_BYTE) begin
            byte_mode_nxt  = 1'b1;
            byte_latch_nxt = in_data_byte;
            bus_level_nxt  = in_data_byte[7:4];
          end else begin
            byte_mode_nxt  = 1'b0;
            byte_latch_nxt = {4'd0, in_data_byte[3:0]};
            bus_level_nxt  = in_data_byte[3:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= lcd4_pkg::PH_IDLE;
      init_step_r     <= 4'd0;
      wait_count_r    <= 16'd0;
      byte_latch_r    <= 8'd0;
      select_latch_r  <= 1'b0;
      low_half_next_r <= 1'b0;
      hold_latch_r    <= 12'd0;
      power_state_r   <= 1'b0;
      driven_state_r  <= 1'b0;
      bus_level_r     <= 4'd0;
      byte_mode_r     <= 1'b0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      init_step_r     <= init_step_nxt;
      wait_count_r    <= wait_count_nxt;
      byte_latch_r    <= byte_latch_nxt;
      select_latch_r  <= select_latch_nxt;
      low_half_next_r <= low_half_next_nxt;
      hold_latch_r    <= hold_latch_nxt;
      power_state_r   <= power_state_nxt;
      driven_state_r  <= driven_state_nxt;
      bus_level_r     <= bus_level_nxt;
      byte_mode_r     <= byte_mode_nxt;
    end
  end

  // result register
  logic       out_valid_r;
  logic       lcd_enable_r, lcd_rs_r, power_enable_r, pins_driven_r, busy_r, rejected_r;
  logic [3:0] lcd_nibble_r;

  assign in_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lcd_enable_r   <= (phase_nxt == lcd4_pkg::PH_STROBE) && driven_state_nxt;
      lcd_rs_r       <= driven_state_nxt && select_latch_nxt;
      lcd_nibble_r   <= driven_state_nxt ? bus_level_nxt : 4'd0;
      power_enable_r <= power_state_nxt;
      pins_driven_r  <= driven_state_nxt;
      busy_r         <= (phase_nxt != lcd4_pkg::PH_IDLE);
      rejected_r     <= rejected;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lcd_enable   = lcd_enable_r;
  assign out_lcd_rs       = lcd_rs_r;
  assign out_lcd_rw       = 1'b0;
  assign out_lcd_nibble   = lcd_nibble_r;
  assign out_power_enable = power_enable_r;
  assign out_pins_driven  = pins_driven_r;
  assign out_busy_res     = busy_r;
  assign out_rejected     = rejected_r;

  // checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lcd_enable |-> out_pins_driven && out_busy_res)
    else $error("enable strobe outside a driven busy write");

  a_power_driven: assert property (@(posedge clk) disable iff (!rst_n)
    driven_state_r |-> power_state_r)
    else $error("pins driven with power off");

  a_power_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lcd4_pkg::PH_POWER |-> init_step_r == 4'd0 && power_state_r)
    else $error("power wait with init already running");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(phase_r) && $stable(wait_count_r))
    else $error("sequencer moved while result stalled");

endmodule
